@@ sv/range_list_packet_decoder_unit_assert.svh @@
// Assertion macros shared by the range list packet decoder RTL
`ifndef RANGE_LIST_PACKET_DECODER_UNIT_ASSERT_SVH
`define RANGE_LIST_PACKET_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RLPD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlpd: same-cycle check failed");
`define RLPD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlpd: next-cycle check failed");
`else
`define RLPD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RLPD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ sv/rlpd_pkg.sv @@
// Types, constants and helper functions of the range list packet decoder
package rlpd_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned DATA_W      = 8;
   localparam int unsigned VALUE_W     = 64;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned LEFT_W      = 4;
   localparam int unsigned KIND_W      = 2;
   localparam int unsigned HEAD_BITS_W = 7;

   localparam logic [LEFT_W-1:0]  LEFT_MAX    = 4'd8;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = 16'hFFFF;

   typedef enum logic [4:0] {
      PH_BIG_COUNT   = 5'b00001,
      PH_BIG_GAP     = 5'b00010,
      PH_BIG_SPAN    = 5'b00100,
      PH_SMALL_COUNT = 5'b01000,
      PH_SMALL_GAPS  = 5'b10000
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_RANGE  = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   // One finished number, or the packet end, handed from front to back
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               done;
      logic               last;
      logic               trunc;
   } token_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] range_from;
      logic [VALUE_W-1:0] range_span;
      logic               last_of_run;
   } result_type;

   function automatic logic [LEFT_W-1:0] leading_ones(input logic [DATA_W-1:0] b);
      logic [LEFT_W-1:0] n;
      logic              run;
      n   = '0;
      run = 1'b1;
      for (int i = DATA_W - 1; i >= 0; i--) begin
         if (run && b[i]) begin
            n = n + 4'd1;
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

   function automatic logic [HEAD_BITS_W-1:0] first_payload(
      input logic [DATA_W-1:0] b,
      input logic [LEFT_W-1:0] n
   );
      logic [HEAD_BITS_W-1:0] mask;
      mask = 7'h7F >> n;
      if (n >= 4'd7) begin
         return '0;
      end
      return b[HEAD_BITS_W-1:0] & mask;
   endfunction

endpackage

@@ sv/rlpd_req_if.sv @@
// Request channel: one packet byte with its end marker
interface rlpd_req_if;
   import rlpd_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              packet_end;

   modport source (output valid, output data_byte, output packet_end, input ready);
   modport sink   (input valid, input data_byte, input packet_end, output ready);
endinterface

@@ sv/rlpd_rsp_if.sv @@
// Response channel: one decoded range or packet status
interface rlpd_rsp_if;
   import rlpd_pkg::*;

   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [VALUE_W-1:0] range_from;
   logic [VALUE_W-1:0] range_span;
   logic               last_of_run;

   modport source (output valid, output kind, output range_from, output range_span,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input range_from, input range_span,
                   input last_of_run, output ready);
endinterface

@@ sv/rlpd_front.sv @@
// Front end: takes bytes and assembles prefix-coded numbers into tokens
module rlpd_front (
   input  logic                clock,
   input  logic                reset,
   rlpd_req_if.sink            req_chan,
   output logic                push,
   output rlpd_pkg::token_type push_data,
   input  logic                full
);
   `include "range_list_packet_decoder_unit_assert.svh"
   import rlpd_pkg::*;

   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [LEFT_W-1:0]  left_ff, left_in;
   logic [LEFT_W-1:0]  left_nx;
   logic [LEFT_W-1:0]  n_ones;
   logic               take;
   logic               done;

   assign req_chan.ready = !full;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      n_ones = leading_ones(req_chan.data_byte);
      if (left_ff == '0) begin
         acc_in  = {{(VALUE_W - HEAD_BITS_W){1'b0}}, first_payload(req_chan.data_byte, n_ones)};
         left_nx = n_ones;
      end else begin
         acc_in  = {acc_ff[VALUE_W-DATA_W-1:0], req_chan.data_byte};
         left_nx = left_ff - 4'd1;
      end
      done = (left_nx == '0);
      // the packet end always restarts the number assembler
      left_in = req_chan.packet_end ? '0 : left_nx;
   end

   assign push            = take && (done || req_chan.packet_end);
   assign push_data.value = acc_in;
   assign push_data.done  = done;
   assign push_data.last  = req_chan.packet_end;
   assign push_data.trunc = !done;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (take) begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         acc_ff <= acc_in;
      end
   end

   `RLPD_ASSERT_IMP(a_left_bounded, clock, reset, 1'b1, left_ff <= LEFT_MAX)
   `RLPD_ASSERT_IMP(a_push_needs_take, clock, reset, push, take && !full)

endmodule

@@ sv/rlpd_queue.sv @@
// Short token queue between the front end and the section engine
module rlpd_queue #(
   parameter int unsigned DEPTH = rlpd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rlpd_pkg::token_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output rlpd_pkg::token_type head
);
   `include "range_list_packet_decoder_unit_assert.svh"
   import rlpd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   token_type         slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (cnt_ff == CNT_FULL);
   assign head_valid = (cnt_ff != '0);
   assign head       = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   `RLPD_ASSERT_IMP(a_cnt_bounded, clock, reset, 1'b1, cnt_ff <= CNT_FULL)
   `RLPD_ASSERT_IMP(a_ptr_gap, clock, reset, !full && head_valid, wr_ff != rd_ff)

endmodule

@@ sv/rlpd_back.sv @@
// Section engine: walks the packet sections and drives the response register
module rlpd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  rlpd_pkg::token_type head,
   output logic                pop,
   rlpd_rsp_if.source          rsp_chan
);
   `include "range_list_packet_decoder_unit_assert.svh"
   import rlpd_pkg::*;

   phase_type          phase_ff, phase_in, phase_up;
   logic [COUNT_W-1:0] expected_ff, expected_in, expected_up;
   logic [COUNT_W-1:0] seen_ff, seen_in, seen_up;
   logic [COUNT_W-1:0] seen_inc;
   logic [VALUE_W-1:0] run_end_ff, run_end_in, run_end_up;
   logic [VALUE_W-1:0] held_from_ff, held_from_in, held_from_up;
   logic               gap_ovf_ff, gap_ovf_in, gap_ovf_up;
   logic               err_ff, err_in, err_up;
   logic               pend_ff, pend_in;
   result_type         out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic               go;
   logic               proc;
   logic [VALUE_W-1:0] add_a;
   logic [VALUE_W:0]   sum;
   logic               has_range;
   logic [VALUE_W-1:0] rng_from;
   logic [VALUE_W-1:0] rng_span;
   logic               ok;
   logic               split;

   assign go       = head_valid && (!out_valid_ff || rsp_chan.ready);
   assign proc     = head.done && !err_ff && !pend_ff;
   assign add_a    = (phase_ff == PH_BIG_SPAN) ? held_from_ff : run_end_ff;
   assign sum      = {1'b0, add_a} + {1'b0, head.value};
   assign seen_inc = seen_ff + 16'd1;

   // Apply one finished number to the section state
   always_comb begin
      phase_up     = phase_ff;
      expected_up  = expected_ff;
      seen_up      = seen_ff;
      run_end_up   = run_end_ff;
      held_from_up = held_from_ff;
      gap_ovf_up   = gap_ovf_ff;
      err_up       = err_ff;
      has_range    = 1'b0;
      rng_from     = '0;
      rng_span     = '0;
      if (proc) begin
         case (phase_ff)
            PH_BIG_COUNT, PH_SMALL_COUNT: begin
               if (head.value >= {{(VALUE_W - COUNT_W){1'b0}}, COUNT_LIMIT}) begin
                  err_up = 1'b1;
               end else begin
                  expected_up = head.value[COUNT_W-1:0];
                  seen_up     = '0;
                  run_end_up  = '0;
                  if (phase_ff == PH_SMALL_COUNT) begin
                     phase_up = PH_SMALL_GAPS;
                  end else if (head.value[COUNT_W-1:0] != '0) begin
                     phase_up = PH_BIG_GAP;
                  end else begin
                     phase_up = PH_SMALL_COUNT;
                  end
               end
            end
            PH_BIG_GAP: begin
               // form the range start now, keep its carry for the span step
               held_from_up = sum[VALUE_W-1:0];
               gap_ovf_up   = sum[VALUE_W];
               phase_up     = PH_BIG_SPAN;
            end
            PH_BIG_SPAN: begin
               if (gap_ovf_ff || sum[VALUE_W]) begin
                  err_up = 1'b1;
               end else begin
                  has_range  = 1'b1;
                  rng_from   = held_from_ff;
                  rng_span   = head.value;
                  run_end_up = sum[VALUE_W-1:0];
                  seen_up    = seen_inc;
                  phase_up   = (seen_inc == expected_ff) ? PH_SMALL_COUNT : PH_BIG_GAP;
               end
            end
            PH_SMALL_GAPS: begin
               if (sum[VALUE_W]) begin
                  err_up = 1'b1;
               end else begin
                  has_range  = 1'b1;
                  rng_from   = sum[VALUE_W-1:0];
                  run_end_up = sum[VALUE_W-1:0];
                  if (seen_ff != COUNT_LIMIT) begin
                     seen_up = seen_inc;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign ok    = !err_up && (phase_up == PH_SMALL_GAPS) && !head.trunc &&
                  (seen_up == expected_up);
   assign split = has_range && head.last;
   assign pop   = go && !split;

   always_comb begin
      phase_in     = phase_ff;
      expected_in  = expected_ff;
      seen_in      = seen_ff;
      run_end_in   = run_end_ff;
      held_from_in = held_from_ff;
      gap_ovf_in   = gap_ovf_ff;
      err_in       = err_ff;
      pend_in      = pend_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (rsp_chan.ready || !out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (go) begin
         phase_in     = phase_up;
         expected_in  = expected_up;
         seen_in      = seen_up;
         run_end_in   = run_end_up;
         held_from_in = held_from_up;
         gap_ovf_in   = gap_ovf_up;
         err_in       = err_up;
         pend_in      = split;
         if (has_range) begin
            out_in.kind        = KIND_RANGE;
            out_in.range_from  = rng_from;
            out_in.range_span  = rng_span;
            out_in.last_of_run = !head.last;
            out_valid_in       = 1'b1;
         end else if (head.last) begin
            out_in.kind        = ok ? KIND_ACCEPT : KIND_REJECT;
            out_in.range_from  = '0;
            out_in.range_span  = '0;
            out_in.last_of_run = 1'b1;
            out_valid_in       = 1'b1;
            // status is out: back to the start of a packet
            phase_in     = PH_BIG_COUNT;
            expected_in  = '0;
            seen_in      = '0;
            run_end_in   = '0;
            held_from_in = '0;
            gap_ovf_in   = 1'b0;
            err_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_BIG_COUNT;
         expected_ff  <= '0;
         seen_ff      <= '0;
         run_end_ff   <= '0;
         held_from_ff <= '0;
         gap_ovf_ff   <= 1'b0;
         err_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         expected_ff  <= expected_in;
         seen_ff      <= seen_in;
         run_end_ff   <= run_end_in;
         held_from_ff <= held_from_in;
         gap_ovf_ff   <= gap_ovf_in;
         err_ff       <= err_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.kind        = out_ff.kind;
   assign rsp_chan.range_from  = out_ff.range_from;
   assign rsp_chan.range_span  = out_ff.range_span;
   assign rsp_chan.last_of_run = out_ff.last_of_run;

   `RLPD_ASSERT_IMP(a_pend_behind_range, clock, reset, pend_ff,
      out_valid_ff && (out_ff.kind == KIND_RANGE) && !out_ff.last_of_run)
   `RLPD_ASSERT_IMP(a_big_tally, clock, reset,
      (phase_ff == PH_BIG_GAP) || (phase_ff == PH_BIG_SPAN), seen_ff < expected_ff)
   `RLPD_ASSERT_NXT(a_err_sticky, clock, reset, err_ff && !(go && head.last), err_ff)

endmodule

@@ sv/range_list_packet_decoder_unit.sv @@
// Range list packet decoder: prefix-coded numbers to decoded ranges and status
//
// req_chan carries one packet byte per request, with packet_end on the final
// byte. rsp_chan returns results: a decoded range (kind 0) as soon as its last
// byte is in, and at the packet end a status (1 accept, 2 reject). last_of_run
// marks the final result caused by one request; one request causes at most two.
// A result passes through the token queue and then the response register before
// it is valid on rsp_chan.
// Throughput: one request per cycle while req_chan.ready is high; a byte that
// closes a range and the packet gives two results, and the section engine
// keeps that token at the queue head for the second one. The front end assembles
// numbers with no feedback from the engine and a small token queue sits between
// the two, so req_chan.ready drops only when that queue is full: behind a stalled
// response register, or briefly after a byte that causes two results.
// Reset (synchronous) empties the queue and the response register and returns
// the decoder to the start of a packet; every packet end does the same for the
// section state. After a bad count or an overflow the rest of the packet is
// dropped up to its end, which reports reject.
module range_list_packet_decoder_unit #(
   parameter int unsigned QUEUE_DEPTH = rlpd_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   rlpd_req_if.sink   req_chan,
   rlpd_rsp_if.source rsp_chan
);
   import rlpd_pkg::*;

   logic      push;
   token_type push_data;
   logic      full;
   logic      pop;
   logic      head_valid;
   token_type head;

   rlpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   rlpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   rlpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the range list packet decoder: directed table, then random packets
module tb;
   import rlpd_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         typed;
      kind_type   status;
   } stim_row_type;

   // Rows marked typed carry their status result by hand; the rest go through the predictor
   stim_row_type directed_rows [22] = '{
      '{8'h00, 1'b1, 1'b1, KIND_REJECT},  // empty big section, no small count
      '{8'h01, 1'b0, 1'b0, KIND_RANGE},
      '{8'h03, 1'b0, 1'b0, KIND_RANGE},
      '{8'h04, 1'b0, 1'b0, KIND_RANGE},
      '{8'h01, 1'b0, 1'b0, KIND_RANGE},
      '{8'h07, 1'b1, 1'b0, KIND_RANGE},   // range and accept from one byte
      '{8'h01, 1'b0, 1'b0, KIND_RANGE},
      '{8'hFF, 1'b0, 1'b0, KIND_RANGE},   // gap of all ones, eight extra bytes
      '{8'hFF, 1'b0, 1'b0, KIND_RANGE},
      '{8'hFF, 1'b0, 1'b0, KIND_RANGE},
      '{8'hFF, 1'b0, 1'b0, KIND_RANGE},
      '{8'hFF, 1'b0, 1'b0, KIND_RANGE},
      '{8'hFF, 1'b0, 1'b0, KIND_RANGE},
      '{8'hFF, 1'b0, 1'b0, KIND_RANGE},
      '{8'hFF, 1'b0, 1'b0, KIND_RANGE},
      '{8'hFF, 1'b0, 1'b0, KIND_RANGE},
      '{8'h01, 1'b0, 1'b0, KIND_RANGE},   // span 1 past the top: overflow
      '{8'h00, 1'b1, 1'b1, KIND_REJECT},
      '{8'hC0, 1'b0, 1'b0, KIND_RANGE},   // count of 65535
      '{8'hFF, 1'b0, 1'b0, KIND_RANGE},
      '{8'hFF, 1'b1, 1'b1, KIND_REJECT},
      '{8'h80, 1'b1, 1'b1, KIND_REJECT}   // number cut short by the packet end
   };

   logic clock;
   logic reset;

   rlpd_req_if req_bus ();
   rlpd_rsp_if rsp_bus ();

   range_list_packet_decoder_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Predictor state
   phase_type   cur_phase;
   logic [63:0] acc_value;
   logic [3:0]  extra_left;
   logic [63:0] held_gap_v;
   logic [63:0] run_end;
   logic [15:0] want_count;
   logic [15:0] got_count;
   logic        bad_packet;

   result_type  pending_results [$];
   result_type  step_results [$];
   logic [7:0]  packet_bytes [$];

   int send_idle_pct = 31;
   int rcv_idle_pct  = 76;
   bit long_hold_go  = 1'b0;

   int error_count   = 0;
   int reports       = 0;
   int ranges_seen   = 0;
   int accepts_seen  = 0;
   int rejects_seen  = 0;
   int packets_sent  = 0;
   int bytes_sent    = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic result_type make_result(kind_type k, logic [63:0] from,
                                              logic [63:0] span);
      result_type r;
      r.kind        = k;
      r.range_from  = from;
      r.range_span  = span;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   task automatic clear_decoder();
      cur_phase  = PH_BIG_COUNT;
      acc_value  = '0;
      extra_left = '0;
      held_gap_v = '0;
      run_end    = '0;
      want_count = '0;
      got_count  = '0;
      bad_packet = 1'b0;
   endtask

   // Work out the results one byte causes into step_results
   task automatic decode_byte(input logic [7:0] b, input logic e);
      int          n;
      logic [63:0] v;
      logic [63:0] from;
      logic        ok;
      step_results.delete();
      if (!bad_packet) begin
         if (extra_left == 0) begin
            n = 0;
            while (n < 8 && b[7 - n]) n++;
            acc_value  = (n >= 7) ? 64'd0 : 64'(b & (8'h7F >> n));
            extra_left = 4'(n);
         end else begin
            acc_value  = {acc_value[55:0], b};
            extra_left = extra_left - 4'd1;
         end
         if (extra_left == 0) begin
            v = acc_value;
            case (cur_phase)
               PH_BIG_COUNT, PH_SMALL_COUNT: begin
                  if (v >= {48'd0, COUNT_LIMIT}) begin
                     bad_packet = 1'b1;
                  end else begin
                     want_count = v[15:0];
                     got_count  = '0;
                     run_end    = '0;
                     if (cur_phase == PH_SMALL_COUNT) begin
                        cur_phase = PH_SMALL_GAPS;
                     end else if (want_count != 0) begin
                        cur_phase = PH_BIG_GAP;
                     end else begin
                        cur_phase = PH_SMALL_COUNT;
                     end
                  end
               end
               PH_BIG_GAP: begin
                  held_gap_v = v;
                  cur_phase  = PH_BIG_SPAN;
               end
               PH_BIG_SPAN: begin
                  from = run_end + held_gap_v;
                  if (held_gap_v > ~run_end || v > ~from) begin
                     bad_packet = 1'b1;
                  end else begin
                     step_results.push_back(make_result(KIND_RANGE, from, v));
                     run_end   = from + v;
                     got_count = got_count + 16'd1;
                     cur_phase = (got_count == want_count) ? PH_SMALL_COUNT : PH_BIG_GAP;
                  end
               end
               default: begin
                  if (v > ~run_end) begin
                     bad_packet = 1'b1;
                  end else begin
                     run_end = run_end + v;
                     step_results.push_back(make_result(KIND_RANGE, run_end, 64'd0));
                     // hold the tally at the limit so it never matches a legal count
                     if (got_count != COUNT_LIMIT) got_count = got_count + 16'd1;
                  end
               end
            endcase
         end
      end
      if (e) begin
         ok = !bad_packet && cur_phase == PH_SMALL_GAPS && extra_left == 0 &&
              got_count == want_count;
         step_results.push_back(make_result(ok ? KIND_ACCEPT : KIND_REJECT, 64'd0, 64'd0));
         clear_decoder();
      end
      if (step_results.size() > 0) step_results[step_results.size() - 1].last_of_run = 1'b1;
   endtask

   // Offer one request from a falling edge; return at the falling edge after acceptance
   task automatic send_req(input logic [7:0] b, input logic e, input bit typed,
                           input kind_type status);
      result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= b;
      req_bus.packet_end <= e;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      decode_byte(b, e);
      if (typed) begin
         r = make_result(status, 64'd0, 64'd0);
         r.last_of_run = 1'b1;
         pending_results.push_back(r);
      end else begin
         foreach (step_results[i]) pending_results.push_back(step_results[i]);
      end
      bytes_sent++;
      if (e) packets_sent++;
      @(negedge clock);
   endtask

   // Prefix-code a number, now and then with more extra bytes than it needs
   task automatic put_number(input logic [63:0] v);
      int         n;
      logic [7:0] head;
      n = 0;
      while (n < 8 && (v >> (7 + 7 * n)) != 0) n++;
      if ($urandom_range(7) == 0) n = $urandom_range(8, n);
      head = 8'hFF << (8 - n);
      if (n < 7) head = head | 8'(v >> (8 * n));
      packet_bytes.push_back(head);
      for (int i = n - 1; i >= 0; i--) packet_bytes.push_back(8'(v >> (8 * i)));
   endtask

   function automatic logic [63:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 64'($urandom_range(0, 100));
      if (r < 80) return {$urandom, $urandom} >> $urandom_range(0, 63);
      if (r < 92) return {$urandom, $urandom};
      return ~64'd0 - 64'($urandom_range(0, 3));
   endfunction

   function automatic logic [63:0] bad_count_value();
      case ($urandom_range(2))
         0:       return {48'd0, COUNT_LIMIT};
         1:       return 64'(COUNT_LIMIT) + 64'($urandom_range(0, 1000));
         default: return {$urandom, $urandom} | 64'h1_0000;
      endcase
   endfunction

   // Mostly well-formed packets; some truncated, some with a bad count, a few pure noise
   task automatic build_packet();
      int form;
      int nb;
      int ns;
      int ng;
      int cut;
      bit bad_big;
      bit bad_small;
      packet_bytes.delete();
      form = $urandom_range(99);
      if (form >= 92) begin
         repeat ($urandom_range(1, 12)) packet_bytes.push_back(8'($urandom));
         return;
      end
      nb        = $urandom_range(0, 4);
      ns        = $urandom_range(0, 4);
      bad_big   = form >= 85 && $urandom_range(1) == 1;
      bad_small = form >= 85 && !bad_big;
      put_number(bad_big ? bad_count_value() : 64'(nb));
      repeat (nb) begin
         put_number(pick_value());
         put_number(pick_value());
      end
      put_number(bad_small ? bad_count_value() : 64'(ns));
      ng = ($urandom_range(9) == 0) ? $urandom_range(0, 5) : ns;
      repeat (ng) put_number(pick_value());
      if (form >= 75 && form < 85) begin
         cut = $urandom_range(1, packet_bytes.size());
         while (packet_bytes.size() > cut) void'(packet_bytes.pop_back());
      end
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
      error_count++;
      reports++;
      if (reports <= 100) $error("%s: expected %0h, got %0h", field, want, got);
   endtask

   // Receiver: random stalls, plus a long hold-off when asked for
   initial begin : rsp_side
      int hold_left;
      bit take_hold;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         take_hold = long_hold_go;
         @(negedge clock);
         if (take_hold) begin
            long_hold_go = 1'b0;
            hold_left    = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   initial begin : rsp_check
      result_type got;
      result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.kind        = rsp_bus.kind;
            got.range_from  = rsp_bus.range_from;
            got.range_span  = rsp_bus.range_span;
            got.last_of_run = rsp_bus.last_of_run;
            case (got.kind)
               KIND_RANGE:  ranges_seen++;
               KIND_ACCEPT: accepts_seen++;
               default:     rejects_seen++;
            endcase
            if (pending_results.size() == 0) begin
               error_count++;
               reports++;
               if (reports <= 100) $error("unexpected result: kind %0d from %0h span %0h",
                                          got.kind, got.range_from, got.range_span);
            end else begin
               want = pending_results.pop_front();
               if (got.kind !== want.kind) report_mismatch("kind", want.kind, got.kind);
               if (got.range_from !== want.range_from)
                  report_mismatch("range_from", want.range_from, got.range_from);
               if (got.range_span !== want.range_span)
                  report_mismatch("range_span", want.range_span, got.range_span);
               if (got.last_of_run !== want.last_of_run)
                  report_mismatch("last_of_run", want.last_of_run, got.last_of_run);
            end
         end
      end
   end

   initial begin : stimulus
      int stage;
      int random_bytes;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.data_byte  = '0;
      req_bus.packet_end = 1'b0;
      clear_decoder();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_req(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                  directed_rows[i].status);
      end

      stage        = 0;
      random_bytes = 0;
      while (random_bytes < 2000) begin
         if (stage == 0 && random_bytes >= 700) begin
            stage         = 1;
            send_idle_pct = 76;
            rcv_idle_pct  = 31;
         end else if (stage == 1 && random_bytes >= 1400) begin
            stage = 2;
            // pause until drained, then hold the receiver off while requests keep coming
            req_bus.valid <= 1'b0;
            do @(negedge clock); while (pending_results.size() != 0);
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
            long_hold_go  = 1'b1;
         end
         build_packet();
         foreach (packet_bytes[i]) begin
            send_req(packet_bytes[i], i == packet_bytes.size() - 1, 1'b0, KIND_RANGE);
            random_bytes++;
         end
      end
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("Sent %0d packets in %0d bytes; checked %0d ranges, %0d accepts, %0d rejects",
               packets_sent, bytes_sent, ranges_seen, accepts_seen, rejects_seen);
      $display("Covered sender and receiver stalls, a long response hold-off and a drain pause");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/rlpd_pkg.sv
sv/rlpd_req_if.sv
sv/rlpd_rsp_if.sv
sv/rlpd_front.sv
sv/rlpd_queue.sv
sv/rlpd_back.sv
sv/range_list_packet_decoder_unit.sv
tb/sv/tb.sv
